[rtl/core/rabs_pkg.sv]
// Package for the running-average background subtractor.
// Holds sizing constants, register codes and the configuration struct.
// No dependencies.
package rabs_pkg;

  localparam int MAX_PIXELS       = 65536;
  localparam int WEIGHT_FRAC_BITS = 12;

  localparam int PIX_W    = 8;
  localparam int ADDR_W   = $clog2(MAX_PIXELS);
  localparam int FRAME_W  = ADDR_W + 1;
  localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;
  localparam int THR_W    = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

  // Register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_OLD_WEIGHT = 2'd1,
    REG_FRAME_PIX  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  // Effective settings as seen by the pixel path
  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAME_W-1:0]  frame_size;
  } cfg_t;

endpackage

[rtl/core/rabs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Self-contained; no package needed.
module rabs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rabs_cfg.sv]
// APB register block: threshold, old weight and frame size.
// Depends on rabs_pkg; delivers clamped settings as a cfg_t.
module rabs_cfg
  import rabs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [THR_W-1:0]    threshold_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [FRAME_W-1:0]  frame_q;
  reg_idx_e            idx;
  logic                wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THR_W'(25);
      weight_q    <= WEIGHT_W'(410);
      frame_q     <= FRAME_W'(MAX_PIXELS);
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD:  threshold_q <= pwdata[THR_W-1:0];
        REG_OLD_WEIGHT: weight_q    <= pwdata[WEIGHT_W-1:0];
        REG_FRAME_PIX:  frame_q     <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD:  prdata = PDATA_W'(threshold_q);
      REG_OLD_WEIGHT: prdata = PDATA_W'(weight_q);
      REG_FRAME_PIX:  prdata = PDATA_W'(frame_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp weight to one, frame size into 1..MAX_PIXELS
  always_comb begin
    cfg_o.threshold = threshold_q;
    cfg_o.weight    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
    if (frame_q == '0) begin
      cfg_o.frame_size = FRAME_W'(1);
    end else if (frame_q > FRAME_W'(MAX_PIXELS)) begin
      cfg_o.frame_size = FRAME_W'(MAX_PIXELS);
    end else begin
      cfg_o.frame_size = frame_q;
    end
  end

endmodule

[rtl/core/rabs_update.sv]
// Per-pixel compare and running-average blend of one background entry.
// Depends on rabs_pkg; purely combinational, sits after the RAM read.
module rabs_update
  import rabs_pkg::*;
(
  input  logic [PIX_W-1:0]    old_i,
  input  logic [PIX_W-1:0]    pix_i,
  input  logic                learn_i,
  input  cfg_t                cfg_i,
  output logic [PIX_W-1:0]    new_o,
  output logic [PIX_W-1:0]    diff_o,
  output logic                fg_o
);

  localparam int DELTA_W = PIX_W + 1;
  localparam int PROD_W  = WEIGHT_W + 1 + DELTA_W;

  logic signed [DELTA_W-1:0] delta;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic [PIX_W-1:0]          abs_diff;

  // w*old + (ONE-w)*pix == ONE*pix + w*(old-pix)
  assign delta = $signed({1'b0, old_i}) - $signed({1'b0, pix_i});
  assign prod  = PROD_W'($signed({1'b0, cfg_i.weight})) * PROD_W'(delta);
  assign acc   = $signed(PROD_W'({pix_i, {WEIGHT_FRAC_BITS{1'b0}}})) + prod;

  assign abs_diff = (old_i > pix_i) ? (old_i - pix_i) : (pix_i - old_i);

  always_comb begin
    if (learn_i) begin
      new_o  = pix_i;
      diff_o = '0;
      fg_o   = 1'b0;
    end else begin
      new_o  = acc[WEIGHT_FRAC_BITS +: PIX_W];
      diff_o = abs_diff;
      fg_o   = abs_diff > cfg_i.threshold;
    end
  end

endmodule

[rtl/core/running_average_background_subtract.sv]
// Top level of the running-average background subtractor.
// Depends on rabs_pkg, rabs_cfg, rabs_ram and rabs_update.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  pixel in | in_valid_i / in_stall_o  | pixel_i, frame_start_i
//  mask out | out_valid_o / out_stall_i| foreground_o, difference_o, learning_o
//  config   | APB psel/penable/pwrite  | paddr, pwdata, prdata
//
// One pixel per clock sustained while out_stall_i is low; a result passes
// through the background RAM read and then the output register.
// The read-modify-write of the background RAM is pipelined; a write that
// lands on the address being read in the same cycle is forwarded.
// Reset clears position, primed flag and pipeline valids; the RAM is not
// cleared, the first frame fills it. A stalled output holds the pipeline.
module running_average_background_subtract
  import rabs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               foreground_o,
  output logic [PIX_W-1:0]   difference_o,
  output logic               learning_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  rabs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Position tracking and read issue
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic               primed_q, primed_d;
  logic [ADDR_W-1:0]  cur;
  logic [FRAME_W-1:0] cur_raw;
  logic [FRAME_W-1:0] nxt;
  logic               accept;

  // Stage after read
  logic               s1_valid_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [PIX_W-1:0]   s1_pix_q;
  logic               s1_learn_q;
  logic               fwd_q;
  logic [PIX_W-1:0]   fwd_data_q;
  logic               s1_adv;
  logic               fwd_hit;
  logic [PIX_W-1:0]   rdata;
  logic [PIX_W-1:0]   old_val;
  logic [PIX_W-1:0]   new_val;
  logic [PIX_W-1:0]   diff_val;
  logic               fg_val;

  // Output register
  logic               out_valid_q;
  logic               fg_q;
  logic [PIX_W-1:0]   diff_q;
  logic               learn_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cur_raw = frame_start_i ? '0 : FRAME_W'(pos_q);
    cur     = (cur_raw >= cfg.frame_size) ? '0 : cur_raw[ADDR_W-1:0];
    nxt     = FRAME_W'(cur) + FRAME_W'(1);
    pos_d    = pos_q;
    primed_d = primed_q;
    if (accept) begin
      if (nxt >= cfg.frame_size) begin
        pos_d    = '0;
        primed_d = 1'b1;
      end else begin
        pos_d = nxt[ADDR_W-1:0];
      end
    end
  end

  // The write of the entry ahead of us lands at the same edge as our read
  assign fwd_hit = s1_adv && (s1_addr_q == cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      primed_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      primed_q <= primed_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= cur;
      s1_pix_q   <= pixel_i;
      s1_learn_q <= !primed_q;
      fwd_q      <= fwd_hit;
      fwd_data_q <= new_val;
    end
    if (s1_adv) begin
      fg_q    <= fg_val;
      diff_q  <= diff_val;
      learn_q <= s1_learn_q;
    end
  end

  rabs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (new_val),
    .re_i    (accept),
    .raddr_i (cur),
    .rdata_o (rdata)
  );

  assign old_val = fwd_q ? fwd_data_q : rdata;

  rabs_update u_update (
    .old_i   (old_val),
    .pix_i   (s1_pix_q),
    .learn_i (s1_learn_q),
    .cfg_i   (cfg),
    .new_o   (new_val),
    .diff_o  (diff_val),
    .fg_o    (fg_val)
  );

  assign out_valid_o  = out_valid_q;
  assign foreground_o = fg_q;
  assign difference_o = diff_q;
  assign learning_o   = learn_q;

endmodule
